[sv/awm_pkg.sv]
package awm_pkg;

  localparam int PAT_MAX_DEF  = 64;
  localparam int ALPHABET_DEF = 256;
  localparam int TABLE_SIZE   = 256;
  localparam int BIN_W        = 8;
  localparam int CNT_W        = 9;
  localparam int TEXT_W       = 32;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_kind_e;

  typedef logic [BIN_W-1:0] bin_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    cmd_kind_e           kind;
    logic                remove;
    bin_t                old_bin;
    bin_t                new_bin;
    logic                emit;
    logic [TEXT_W-1:0]   win_start;
  } cmd_t;

  typedef logic [TABLE_SIZE-1:0][BIN_W-1:0] bin_lut_t;

  // byte -> bin fold, built at elaboration by repeated subtraction
  function automatic bin_lut_t make_bin_lut(int alphabet);
    bin_lut_t lut;
    int       r;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      r = i;
      while (r >= alphabet) begin
        r = r - alphabet;
      end
      lut[i] = BIN_W'(r);
    end
    return lut;
  endfunction

endpackage

[sv/awm_front.sv]
module awm_front #(
  parameter int PAT_MAX  = awm_pkg::PAT_MAX_DEF,
  parameter int ALPHABET = awm_pkg::ALPHABET_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          char_byte_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output awm_pkg::cmd_t       cmd_o
);

  localparam int PL_W    = $clog2(PAT_MAX + 1);
  localparam int RING_AW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam awm_pkg::bin_lut_t BinLut = awm_pkg::make_bin_lut(ALPHABET);

  logic [PL_W-1:0]            plen_q, plen_d;
  logic [RING_AW-1:0]         ptr_q, ptr_d;
  logic [awm_pkg::TEXT_W-1:0] tc_q, tc_d, tc_inc;
  logic                       stage_valid_q, stage_valid_d;
  awm_pkg::cmd_t              stage_q, cmd_new;
  logic                       gen;
  logic                       ring_we;
  logic                       in_fire;
  awm_pkg::bin_t              new_bin;
  awm_pkg::bin_t              ring_q [PAT_MAX];
  awm_pkg::bin_t              ring_rd_q;

  assign in_ready_o = !stage_valid_q || cmd_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign new_bin    = BinLut[char_byte_i];
  assign tc_inc     = (tc_q != '1) ? tc_q + awm_pkg::TEXT_W'(1) : tc_q;

  always_comb begin
    plen_d            = plen_q;
    ptr_d             = ptr_q;
    tc_d              = tc_q;
    gen               = 1'b0;
    ring_we           = 1'b0;
    cmd_new.kind      = awm_pkg::CMD_CLEAR;
    cmd_new.remove    = 1'b0;
    cmd_new.old_bin   = '0;
    cmd_new.new_bin   = new_bin;
    cmd_new.emit      = 1'b0;
    cmd_new.win_start = tc_inc - awm_pkg::TEXT_W'(plen_q);
    case (awm_pkg::opcode_e'(opcode_i))
      awm_pkg::OP_CLEAR: begin
        plen_d = '0;
        ptr_d  = '0;
        tc_d   = '0;
        gen    = 1'b1;
      end
      awm_pkg::OP_PATTERN: begin
        if (plen_q < PL_W'(PAT_MAX) && tc_q == '0) begin
          plen_d       = plen_q + PL_W'(1);
          gen          = 1'b1;
          cmd_new.kind = awm_pkg::CMD_PATTERN;
        end
      end
      awm_pkg::OP_TEXT: begin
        if (plen_q != '0) begin
          gen            = 1'b1;
          ring_we        = 1'b1;
          cmd_new.kind   = awm_pkg::CMD_TEXT;
          cmd_new.remove = tc_q >= awm_pkg::TEXT_W'(plen_q);
          cmd_new.emit   = tc_inc >= awm_pkg::TEXT_W'(plen_q);
          tc_d           = tc_inc;
          ptr_d          = (PL_W'(ptr_q) + PL_W'(1) == plen_q) ? '0 : ptr_q + RING_AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (in_fire) begin
      stage_valid_d = gen;
    end else begin
      stage_valid_d = stage_valid_q && !cmd_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q        <= '0;
      ptr_q         <= '0;
      tc_q          <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      if (in_fire) begin
        plen_q <= plen_d;
        ptr_q  <= ptr_d;
        tc_q   <= tc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && gen) begin
      stage_q <= cmd_new;
    end
  end

  // ring keeps folded bins; read-before-write gives the byte leaving the window
  always_ff @(posedge clk_i) begin
    if (in_fire && ring_we) begin
      ring_rd_q     <= ring_q[ptr_q];
      ring_q[ptr_q] <= new_bin;
    end
  end

  always_comb begin
    cmd_o         = stage_q;
    cmd_o.old_bin = ring_rd_q;
  end

  assign cmd_valid_o = stage_valid_q;

endmodule

[sv/awm_queue.sv]
module awm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  awm_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output awm_pkg::cmd_t pop_data_o
);

  localparam int Depth = awm_pkg::QUEUE_DEPTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  awm_pkg::cmd_t   buf_q [Depth];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   count_q;
  logic            push, pop;

  assign push_ready_o = count_q != CW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = buf_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
      end
      count_q <= count_q + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[sv/awm_back.sv]
module awm_back #(
  parameter int PAT_MAX = awm_pkg::PAT_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  awm_pkg::cmd_t              cmd_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       match_o,
  output logic [awm_pkg::TEXT_W-1:0] window_start_o
);

  localparam int DIFF_W = $clog2(PAT_MAX + 1) + 1;

  typedef logic signed [DIFF_W-1:0] diff_t;

  // issue
  logic                       phase_q, phase_d;
  logic                       pop, issue, room;
  logic                       sub_emit, sub_dec, sub_clear;
  awm_pkg::bin_t              sub_addr;

  // read-modify-write stage
  logic                       s1_valid_q, s1_clear_q, s1_dec_q, s1_emit_q, s1_fresh_q;
  awm_pkg::bin_t              s1_addr_q;
  logic [awm_pkg::TEXT_W-1:0] s1_start_q;
  logic                       s1_wr, s1_clr, s1_push;
  diff_t                      tbl_q [awm_pkg::TABLE_SIZE];
  diff_t                      tbl_rd_q;
  logic [awm_pkg::TABLE_SIZE-1:0] vld_q;
  logic                       vld_rd_q;
  logic                       fw_valid_q;
  awm_pkg::bin_t              fw_addr_q;
  diff_t                      fw_data_q;
  diff_t                      cur, nxt;
  logic [awm_pkg::CNT_W-1:0]  nz_q, nz_d;

  // result buffer
  logic                       obuf_match_q [2];
  logic [awm_pkg::TEXT_W-1:0] obuf_start_q [2];
  logic                       owptr_q, orptr_q;
  logic [1:0]                 ocount_q;
  logic                       out_pop;

  always_comb begin
    pop       = 1'b0;
    phase_d   = phase_q;
    sub_addr  = cmd_i.new_bin;
    sub_dec   = 1'b0;
    sub_emit  = 1'b0;
    sub_clear = 1'b0;
    case (cmd_i.kind)
      awm_pkg::CMD_CLEAR: begin
        sub_clear = 1'b1;
        pop       = 1'b1;
        phase_d   = 1'b0;
      end
      awm_pkg::CMD_PATTERN: begin
        sub_dec = 1'b1;
        pop     = 1'b1;
      end
      awm_pkg::CMD_TEXT: begin
        if (cmd_i.remove && !phase_q) begin
          sub_addr = cmd_i.old_bin;
          sub_dec  = 1'b1;
          phase_d  = 1'b1;
        end else begin
          sub_emit = cmd_i.emit;
          pop      = 1'b1;
          phase_d  = 1'b0;
        end
      end
      default: begin
        pop = 1'b1;
      end
    endcase
  end

  assign out_pop     = out_valid_o && out_ready_i;
  assign s1_push     = s1_valid_q && s1_emit_q;
  assign room        = ({1'b0, ocount_q} + 3'(s1_push) - 3'(out_pop)) <= 3'd1;
  assign issue       = cmd_valid_i && (!sub_emit || room);
  assign cmd_ready_o = issue && pop;

  assign s1_clr = s1_valid_q && s1_clear_q;
  assign s1_wr  = s1_valid_q && !s1_clear_q;

  always_comb begin
    if (s1_fresh_q) begin
      cur = '0;
    end else if (fw_valid_q && fw_addr_q == s1_addr_q) begin
      cur = fw_data_q;
    end else if (vld_rd_q) begin
      cur = tbl_rd_q;
    end else begin
      cur = '0;
    end
    nxt = s1_dec_q ? cur - diff_t'(1) : cur + diff_t'(1);
  end

  always_comb begin
    nz_d = nz_q;
    if (s1_clr) begin
      nz_d = '0;
    end else if (s1_wr) begin
      if (cur == '0 && nxt != '0) begin
        nz_d = nz_q + awm_pkg::CNT_W'(1);
      end else if (cur != '0 && nxt == '0) begin
        nz_d = nz_q - awm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_fresh_q <= 1'b0;
      fw_valid_q <= 1'b0;
      vld_q      <= '0;
      nz_q       <= '0;
      owptr_q    <= 1'b0;
      orptr_q    <= 1'b0;
      ocount_q   <= '0;
    end else begin
      if (issue) begin
        phase_q <= phase_d;
      end
      s1_valid_q <= issue;
      s1_fresh_q <= s1_clr;
      fw_valid_q <= s1_wr;
      nz_q       <= nz_d;
      if (s1_clr) begin
        vld_q <= '0;
      end else if (s1_wr) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
      if (s1_push) begin
        owptr_q <= !owptr_q;
      end
      if (out_pop) begin
        orptr_q <= !orptr_q;
      end
      ocount_q <= ocount_q + 2'(s1_push) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_addr_q  <= sub_addr;
      s1_dec_q   <= sub_dec;
      s1_emit_q  <= sub_emit;
      s1_clear_q <= sub_clear;
      s1_start_q <= cmd_i.win_start;
      tbl_rd_q   <= tbl_q[sub_addr];
      vld_rd_q   <= vld_q[sub_addr];
    end
    if (s1_wr) begin
      tbl_q[s1_addr_q] <= nxt;
      fw_addr_q        <= s1_addr_q;
      fw_data_q        <= nxt;
    end
    if (s1_push) begin
      obuf_match_q[owptr_q] <= nz_d == '0;
      obuf_start_q[owptr_q] <= s1_start_q;
    end
  end

  assign out_valid_o    = ocount_q != '0;
  assign match_o        = obuf_match_q[orptr_q];
  assign window_start_o = obuf_start_q[orptr_q];

endmodule

[sv/anagram_window_matcher_top.sv]
// Sliding-window anagram search over a byte stream.
// Input channel (in_valid_i/in_ready_o): opcode_i with char_byte_i. A clear
// item starts a new search, pattern items load the pattern, text items follow.
// Output channel (out_valid_o/out_ready_i): one item per text byte once a full
// pattern-length window has been seen, with match_o and window_start_o.
// Path: an accepted text item passes the front stage register, the queue, the
// back end's read-modify-write stage and the result buffer to out_valid_o.
// Once the window is full, a text byte updates two bins of the difference
// table through its single write port, first the bin of the byte leaving the
// window, then its own, so the back end issues it once per bin. The front
// accepts an item every cycle while the queue has room; a 4-entry queue
// decouples it from the table back end, and a 2-entry result buffer sits at
// the output. Reset: table, counts and pattern are empty; no clearing pass
// is needed, as table entries carry valid bits that reset and clear items
// drop at once. Receiver stall: results wait in the buffer, the back end
// stops issuing, the queue fills, then in_ready_o drops.
module anagram_window_matcher_top #(
  parameter int PAT_MAX  = awm_pkg::PAT_MAX_DEF,
  parameter int ALPHABET = awm_pkg::ALPHABET_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [7:0]                 char_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       match_o,
  output logic [awm_pkg::TEXT_W-1:0] window_start_o
);

  logic          f_valid, f_ready;
  awm_pkg::cmd_t f_cmd;
  logic          b_valid, b_ready;
  awm_pkg::cmd_t b_cmd;

  awm_front #(
    .PAT_MAX  (PAT_MAX),
    .ALPHABET (ALPHABET)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .char_byte_i (char_byte_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  awm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  awm_back #(
    .PAT_MAX (PAT_MAX)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (b_valid),
    .cmd_ready_o    (b_ready),
    .cmd_i          (b_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .match_o        (match_o),
    .window_start_o (window_start_o)
  );

endmodule

[sv/awm_checker.sv]
module awm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [1:0]                 opcode_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       match_o,
  input logic [awm_pkg::TEXT_W-1:0] window_start_o
);

  logic text_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_seen_q <= 1'b0;
    end else if (in_valid_i && in_ready_o && opcode_i == awm_pkg::OP_TEXT) begin
      text_seen_q <= 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(match_o) && $stable(window_start_o))
    else $error("result changed while stalled");

  // results only come from text items
  a_out_needs_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> text_seen_q)
    else $error("result without any text item");

  // nothing pending right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result pending after reset");

  // no result shows right after the first text item, while it is still in the pipeline
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(text_seen_q) |-> !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)
    else $error("result earlier than pipeline latency");

endmodule

bind anagram_window_matcher_top awm_checker u_checker (.*);
